// ===== hw/rtl/glif_neuron_step_with_spike_core_macros.svh =====
// ---------------------------------------------------------------------------
// glif assertion macros
// concurrent assertion shorthands used by the port checker
// ---------------------------------------------------------------------------
`ifndef GLIF_NEURON_STEP_WITH_SPIKE_CORE_MACROS_SVH
`define GLIF_NEURON_STEP_WITH_SPIKE_CORE_MACROS_SVH

// same-cycle implication
`define GLIF_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GLIF_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/glif_pkg.sv =====
// ---------------------------------------------------------------------------
// glif package
// types, constants, saturating helpers and the micro-op table of the neuron step
// ---------------------------------------------------------------------------
package glif_pkg;

    localparam int COEFFS_PER_NEURON = 28;
    localparam int BASIS_COUNT       = 4;
    localparam logic [4:0] PERIOD_SLOT = 5'd28;

    localparam logic signed [31:0] FX_ONE = 32'sd16777216;
    localparam logic signed [31:0] FX_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] FX_MIN = 32'sh80000000;
    localparam logic signed [63:0] FX_HALF64 = 64'sd8388608;

    localparam logic [5:0] STEP_SPIKE = 6'd37;
    localparam logic [5:0] STEP_LAST  = 6'd43;

    typedef enum logic [1:0] {
        REG_TIME_STEP  = 2'd0,
        REG_THRESHOLD  = 2'd1,
        REG_HARD_RESET = 2'd2
    } glif_reg_t;

    typedef enum logic [4:0] {
        A_ADAPT0, A_ADAPT1, A_RISE0, A_RISE1, A_RISE2, A_RISE3,
        A_PSC0, A_PSC1, A_PSC2, A_PSC3, A_CUR0, A_CUR1, A_CUR2, A_CUR3,
        A_STEP, A_VOLT, A_K0, A_K2, A_MEAN, A_DAMP, A_COEF
    } a_sel_t;

    typedef enum logic [1:0] {B_COEF, B_OMC, B_ONE, B_U} b_sel_t;

    typedef enum logic [2:0] {D_ZERO, D_T, D_K0, D_K1, D_K2, D_K3} add_sel_t;

    typedef enum logic [4:0] {
        W_T, W_U, W_K0, W_K1, W_K2, W_K3, W_NR0, W_NR1, W_NR2, W_NR3,
        W_NP0, W_NP1, W_NP2, W_NP3, W_MEAN, W_DAMP, W_CAND, W_R26,
        W_ADAPT0, W_ADAPT1
    } dst_t;

    typedef enum logic [1:0] {C_ALWAYS, C_ACTIVE, C_FIRED} cond_t;

    typedef struct packed {
        a_sel_t     a_sel;
        b_sel_t     b_sel;
        add_sel_t   add_sel;
        dst_t       dst;
        logic [4:0] slot;
        cond_t      cond;
    } uop_t;

    typedef struct packed {
        logic       clearing;
        logic       capture;
        logic       load;
        logic       latch;
        logic       mul;
        logic       wb;
        logic       spike1;
        logic       spike2;
        logic       write;
        uop_t       uop;
        logic [4:0] coef_slot;
    } glif_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic in_range;
        logic out_busy;
    } glif_sts_t;

    typedef struct packed {
        logic [3:0][31:0] psc;
        logic [3:0][31:0] rise;
        logic [1:0][31:0] adapt;
        logic [14:0]      refr;
        logic [31:0]      volt;
    } glif_row_t;

    function automatic logic signed [31:0] fx_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            return s[32] ? FX_MIN : FX_MAX;
        end
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] fx_neg(input logic signed [31:0] a);
        if (a == FX_MIN) begin
            return FX_MAX;
        end
        return -a;
    endfunction

    function automatic logic signed [31:0] fx_sat64(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return FX_MAX;
        end
        if (x < -64'sd2147483648) begin
            return FX_MIN;
        end
        return x[31:0];
    endfunction

    // one micro-op per step of the shared multiply-add unit
    function automatic uop_t glif_uop(input logic [5:0] step);
        uop_t u;
        u = '{A_COEF, B_ONE, D_ZERO, W_U, 5'd0, C_ALWAYS};
        case (step)
            6'd0:  u = '{A_ADAPT1, B_COEF, D_ZERO, W_T,    5'd15, C_ALWAYS};
            6'd1:  u = '{A_ADAPT0, B_COEF, D_T,    W_MEAN, 5'd14, C_ALWAYS};
            6'd2:  u = '{A_RISE0,  B_COEF, D_ZERO, W_T,    5'd22, C_ALWAYS};
            6'd3:  u = '{A_PSC0,   B_COEF, D_T,    W_K0,   5'd18, C_ALWAYS};
            6'd4:  u = '{A_CUR0,   B_COEF, D_ZERO, W_T,    5'd4,  C_ALWAYS};
            6'd5:  u = '{A_RISE0,  B_COEF, D_T,    W_NR0,  5'd0,  C_ALWAYS};
            6'd6:  u = '{A_STEP,   B_COEF, D_ZERO, W_U,    5'd0,  C_ALWAYS};
            6'd7:  u = '{A_RISE0,  B_U,    D_ZERO, W_T,    5'd0,  C_ALWAYS};
            6'd8:  u = '{A_PSC0,   B_COEF, D_T,    W_NP0,  5'd0,  C_ALWAYS};
            6'd9:  u = '{A_RISE1,  B_COEF, D_ZERO, W_T,    5'd23, C_ALWAYS};
            6'd10: u = '{A_PSC1,   B_COEF, D_T,    W_K1,   5'd19, C_ALWAYS};
            6'd11: u = '{A_CUR1,   B_COEF, D_ZERO, W_T,    5'd5,  C_ALWAYS};
            6'd12: u = '{A_RISE1,  B_COEF, D_T,    W_NR1,  5'd1,  C_ALWAYS};
            6'd13: u = '{A_STEP,   B_COEF, D_ZERO, W_U,    5'd1,  C_ALWAYS};
            6'd14: u = '{A_RISE1,  B_U,    D_ZERO, W_T,    5'd1,  C_ALWAYS};
            6'd15: u = '{A_PSC1,   B_COEF, D_T,    W_NP1,  5'd1,  C_ALWAYS};
            6'd16: u = '{A_RISE2,  B_COEF, D_ZERO, W_T,    5'd24, C_ALWAYS};
            6'd17: u = '{A_PSC2,   B_COEF, D_T,    W_K2,   5'd20, C_ALWAYS};
            6'd18: u = '{A_CUR2,   B_COEF, D_ZERO, W_T,    5'd6,  C_ALWAYS};
            6'd19: u = '{A_RISE2,  B_COEF, D_T,    W_NR2,  5'd2,  C_ALWAYS};
            6'd20: u = '{A_STEP,   B_COEF, D_ZERO, W_U,    5'd2,  C_ALWAYS};
            6'd21: u = '{A_RISE2,  B_U,    D_ZERO, W_T,    5'd2,  C_ALWAYS};
            6'd22: u = '{A_PSC2,   B_COEF, D_T,    W_NP2,  5'd2,  C_ALWAYS};
            6'd23: u = '{A_RISE3,  B_COEF, D_ZERO, W_T,    5'd25, C_ALWAYS};
            6'd24: u = '{A_PSC3,   B_COEF, D_T,    W_K3,   5'd21, C_ALWAYS};
            6'd25: u = '{A_CUR3,   B_COEF, D_ZERO, W_T,    5'd7,  C_ALWAYS};
            6'd26: u = '{A_RISE3,  B_COEF, D_T,    W_NR3,  5'd3,  C_ALWAYS};
            6'd27: u = '{A_STEP,   B_COEF, D_ZERO, W_U,    5'd3,  C_ALWAYS};
            6'd28: u = '{A_RISE3,  B_U,    D_ZERO, W_T,    5'd3,  C_ALWAYS};
            6'd29: u = '{A_PSC3,   B_COEF, D_T,    W_NP3,  5'd3,  C_ALWAYS};
            6'd30: u = '{A_VOLT,   B_OMC,  D_ZERO, W_T,    5'd27, C_ALWAYS};
            6'd31: u = '{A_VOLT,   B_COEF, D_T,    W_DAMP, 5'd27, C_ALWAYS};
            6'd32: u = '{A_K0,     B_ONE,  D_K1,   W_K0,   5'd0,  C_ALWAYS};
            6'd33: u = '{A_K2,     B_ONE,  D_K3,   W_K2,   5'd0,  C_ALWAYS};
            6'd34: u = '{A_K0,     B_ONE,  D_K2,   W_K0,   5'd0,  C_ALWAYS};
            6'd35: u = '{A_MEAN,   B_COEF, D_K0,   W_T,    5'd13, C_ALWAYS};
            6'd36: u = '{A_DAMP,   B_COEF, D_T,    W_CAND, 5'd12, C_ALWAYS};
            6'd37: u = '{A_COEF,   B_ONE,  D_ZERO, W_R26,  5'd26, C_ALWAYS};
            6'd38: u = '{A_ADAPT0, B_COEF, D_ZERO, W_ADAPT0, 5'd8,  C_ACTIVE};
            6'd39: u = '{A_ADAPT0, B_COEF, D_ZERO, W_T,      5'd16, C_ALWAYS};
            6'd40: u = '{A_COEF,   B_ONE,  D_T,    W_ADAPT0, 5'd10, C_FIRED};
            6'd41: u = '{A_ADAPT1, B_COEF, D_ZERO, W_ADAPT1, 5'd9,  C_ACTIVE};
            6'd42: u = '{A_ADAPT1, B_COEF, D_ZERO, W_T,      5'd17, C_ALWAYS};
            6'd43: u = '{A_COEF,   B_ONE,  D_T,    W_ADAPT1, 5'd11, C_FIRED};
            default: u = '{A_COEF, B_ONE, D_ZERO, W_U, 5'd0, C_ALWAYS};
        endcase
        return u;
    endfunction

endpackage

// ===== hw/rtl/glif_ram.sv =====
// ---------------------------------------------------------------------------
// glif generic ram
// simple dual-port memory, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module glif_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== hw/rtl/glif_ctrl.sv =====
// ---------------------------------------------------------------------------
// glif controller
// sequences the clearing pass, state fetch, micro-op steps, spike and write back
// ---------------------------------------------------------------------------
module glif_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_mode,
    output logic                s_ready,
    input  glif_pkg::glif_sts_t sts,
    output glif_pkg::glif_cmd_t cmd
);
    import glif_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_FETCH, ST_LATCH, ST_MUL, ST_WB,
        ST_SPIKE1, ST_SPIKE2, ST_WRITE
    } state_t;

    state_t     state_reg;
    logic [5:0] step_reg;
    logic [5:0] step_next;
    uop_t       ahead;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            step_reg  <= '0;
        end else begin
            case (state_reg)
                ST_CLEAR: begin
                    if (sts.clear_last) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid && !s_mode && sts.in_range) begin
                        state_reg <= ST_FETCH;
                        step_reg  <= '0;
                    end
                end
                ST_FETCH:  state_reg <= ST_LATCH;
                ST_LATCH:  state_reg <= ST_MUL;
                ST_MUL:    state_reg <= ST_WB;
                ST_WB: begin
                    step_reg <= step_next;
                    if (step_reg == STEP_SPIKE) begin
                        state_reg <= ST_SPIKE1;
                    end else if (step_reg == STEP_LAST) begin
                        state_reg <= ST_WRITE;
                    end else begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_SPIKE1: state_reg <= ST_SPIKE2;
                ST_SPIKE2: state_reg <= ST_MUL;
                ST_WRITE: begin
                    if (!sts.out_busy) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:   state_reg <= ST_CLEAR;
            endcase
        end
    end

    assign step_next = step_reg + 6'd1;
    assign s_ready   = (state_reg == ST_IDLE);

    // coefficient address runs one step ahead during write back
    assign ahead = glif_uop((state_reg == ST_WB) ? step_next : step_reg);

    always_comb begin
        cmd           = '0;
        cmd.clearing  = (state_reg == ST_CLEAR);
        cmd.capture   = (state_reg == ST_IDLE) && s_valid && !s_mode && sts.in_range;
        cmd.load      = (state_reg == ST_IDLE) && s_valid && s_mode && sts.in_range;
        cmd.latch     = (state_reg == ST_LATCH);
        cmd.mul       = (state_reg == ST_MUL);
        cmd.wb        = (state_reg == ST_WB);
        cmd.spike1    = (state_reg == ST_SPIKE1);
        cmd.spike2    = (state_reg == ST_SPIKE2);
        cmd.write     = (state_reg == ST_WRITE) && !sts.out_busy;
        cmd.uop       = glif_uop(step_reg);
        cmd.coef_slot = ahead.slot;
    end
endmodule

// ===== hw/rtl/glif_dp.sv =====
// ---------------------------------------------------------------------------
// glif datapath
// state memories, operand registers, shared multiply-add unit and result register
// ---------------------------------------------------------------------------
module glif_dp #(
    parameter int NUM_NEURONS = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  glif_pkg::glif_cmd_t cmd,
    output glif_pkg::glif_sts_t sts,
    input  logic [7:0]          s_neuron,
    input  logic [4:0]          s_slot,
    input  logic signed [31:0]  s_coefficient,
    input  logic signed [31:0]  s_current_0,
    input  logic signed [31:0]  s_current_1,
    input  logic signed [31:0]  s_current_2,
    input  logic signed [31:0]  s_current_3,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_neuron_out,
    output logic                m_spiked,
    output logic signed [31:0]  m_margin,
    output logic signed [31:0]  m_voltage_out,
    output logic [14:0]         m_refractory_left
);
    import glif_pkg::*;

    localparam int NW     = (NUM_NEURONS > 1) ? $clog2(NUM_NEURONS) : 1;
    localparam int CDEPTH = NUM_NEURONS * COEFFS_PER_NEURON;
    localparam int CW     = $clog2(CDEPTH);
    localparam int ROW_W  = $bits(glif_row_t);

    // configuration
    logic signed [31:0] time_step_reg;
    logic signed [31:0] threshold_reg;
    logic               hard_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg <= '0;
            threshold_reg <= FX_ONE;
            hard_reg      <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TIME_STEP:  time_step_reg <= cfg_data;
                REG_THRESHOLD:  threshold_reg <= cfg_data;
                REG_HARD_RESET: hard_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // clearing pass counter
    logic [NW-1:0] clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clearing) begin
            clr_cnt_reg <= clr_cnt_reg + NW'(1);
        end
    end

    // memories
    logic [7:0]      n_reg;
    glif_row_t       row_rdata;
    glif_row_t       row_wdata;
    logic            row_we;
    logic [NW-1:0]   row_waddr;
    logic [31:0]     coef_rdata;
    logic [CW-1:0]   coef_waddr;
    logic [CW-1:0]   coef_raddr;
    logic [14:0]     period_rdata;
    logic            coef_we;
    logic            period_we;

    assign coef_we    = cmd.load && (s_slot < PERIOD_SLOT);
    assign period_we  = cmd.load && (s_slot == PERIOD_SLOT);
    assign coef_waddr = CW'(s_neuron) * CW'(COEFFS_PER_NEURON) + CW'(s_slot);
    assign coef_raddr = CW'(n_reg) * CW'(COEFFS_PER_NEURON) + CW'(cmd.coef_slot);

    glif_ram #(.WIDTH(ROW_W), .DEPTH(NUM_NEURONS)) u_row_ram (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .raddr (NW'(n_reg)),
        .rdata (row_rdata)
    );

    glif_ram #(.WIDTH(32), .DEPTH(CDEPTH)) u_coef_ram (
        .aclk  (aclk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (s_coefficient),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    glif_ram #(.WIDTH(15), .DEPTH(NUM_NEURONS)) u_period_ram (
        .aclk  (aclk),
        .we    (period_we),
        .waddr (NW'(s_neuron)),
        .wdata (s_coefficient[14:0]),
        .raddr (NW'(n_reg)),
        .rdata (period_rdata)
    );

    // operand and working registers
    logic signed [31:0] cur_reg   [4];
    logic signed [31:0] rise_reg  [4];
    logic signed [31:0] psc_reg   [4];
    logic signed [31:0] nrise_reg [4];
    logic signed [31:0] npsc_reg  [4];
    logic signed [31:0] k_reg     [4];
    logic signed [31:0] adapt_reg [2];
    logic signed [31:0] volt_reg;
    logic [14:0]        refr_reg;
    logic [14:0]        period_reg;
    logic signed [31:0] t_reg;
    logic signed [31:0] u_reg;
    logic signed [31:0] mean_reg;
    logic signed [31:0] damp_reg;
    logic signed [31:0] cand_reg;
    logic signed [31:0] r26_reg;
    logic signed [31:0] before_reg;
    logic signed [31:0] margin_reg;
    logic signed [31:0] sub_reg;
    logic signed [31:0] nv_reg;
    logic [14:0]        nr_reg;
    logic               fired_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] add_reg;

    logic signed [31:0] a_op;
    logic signed [31:0] b_op;
    logic signed [31:0] add_op;
    logic signed [63:0] rounded;
    logic signed [31:0] wb_res;
    logic               active;
    logic               cond_ok;
    logic signed [31:0] before_c;
    logic               fired_c;

    assign active = (refr_reg == 15'd0);

    always_comb begin
        case (cmd.uop.a_sel)
            A_ADAPT0: a_op = adapt_reg[0];
            A_ADAPT1: a_op = adapt_reg[1];
            A_RISE0:  a_op = rise_reg[0];
            A_RISE1:  a_op = rise_reg[1];
            A_RISE2:  a_op = rise_reg[2];
            A_RISE3:  a_op = rise_reg[3];
            A_PSC0:   a_op = psc_reg[0];
            A_PSC1:   a_op = psc_reg[1];
            A_PSC2:   a_op = psc_reg[2];
            A_PSC3:   a_op = psc_reg[3];
            A_CUR0:   a_op = cur_reg[0];
            A_CUR1:   a_op = cur_reg[1];
            A_CUR2:   a_op = cur_reg[2];
            A_CUR3:   a_op = cur_reg[3];
            A_STEP:   a_op = time_step_reg;
            A_VOLT:   a_op = volt_reg;
            A_K0:     a_op = k_reg[0];
            A_K2:     a_op = k_reg[2];
            A_MEAN:   a_op = mean_reg;
            A_DAMP:   a_op = damp_reg;
            A_COEF:   a_op = coef_rdata;
            default:  a_op = '0;
        endcase
        case (cmd.uop.b_sel)
            B_COEF:  b_op = coef_rdata;
            B_OMC:   b_op = fx_add(FX_ONE, fx_neg(coef_rdata));
            B_ONE:   b_op = FX_ONE;
            B_U:     b_op = u_reg;
            default: b_op = '0;
        endcase
        case (cmd.uop.add_sel)
            D_ZERO:  add_op = '0;
            D_T:     add_op = t_reg;
            D_K0:    add_op = k_reg[0];
            D_K1:    add_op = k_reg[1];
            D_K2:    add_op = k_reg[2];
            D_K3:    add_op = k_reg[3];
            default: add_op = '0;
        endcase
        case (cmd.uop.cond)
            C_ALWAYS: cond_ok = 1'b1;
            C_ACTIVE: cond_ok = active;
            C_FIRED:  cond_ok = fired_reg;
            default:  cond_ok = 1'b0;
        endcase
    end

    // round to nearest, ties up, then saturate and add
    assign rounded = (prod_reg + FX_HALF64) >>> 24;
    assign wb_res  = fx_add(fx_sat64(rounded), add_reg);

    assign before_c = (hard_reg && !active) ? r26_reg : cand_reg;
    assign fired_c  = active && !margin_reg[31] && (margin_reg != 32'sd0);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            n_reg      <= s_neuron;
            cur_reg[0] <= s_current_0;
            cur_reg[1] <= s_current_1;
            cur_reg[2] <= s_current_2;
            cur_reg[3] <= s_current_3;
        end
        if (cmd.latch) begin
            volt_reg     <= row_rdata.volt;
            refr_reg     <= row_rdata.refr;
            adapt_reg[0] <= row_rdata.adapt[0];
            adapt_reg[1] <= row_rdata.adapt[1];
            for (int b = 0; b < BASIS_COUNT; b++) begin
                rise_reg[b] <= row_rdata.rise[b];
                psc_reg[b]  <= row_rdata.psc[b];
            end
            period_reg <= period_rdata;
        end
        if (cmd.mul) begin
            prod_reg <= a_op * b_op;
            add_reg  <= add_op;
        end
        if (cmd.wb && cond_ok) begin
            case (cmd.uop.dst)
                W_T:      t_reg        <= wb_res;
                W_U:      u_reg        <= wb_res;
                W_K0:     k_reg[0]     <= wb_res;
                W_K1:     k_reg[1]     <= wb_res;
                W_K2:     k_reg[2]     <= wb_res;
                W_K3:     k_reg[3]     <= wb_res;
                W_NR0:    nrise_reg[0] <= wb_res;
                W_NR1:    nrise_reg[1] <= wb_res;
                W_NR2:    nrise_reg[2] <= wb_res;
                W_NR3:    nrise_reg[3] <= wb_res;
                W_NP0:    npsc_reg[0]  <= wb_res;
                W_NP1:    npsc_reg[1]  <= wb_res;
                W_NP2:    npsc_reg[2]  <= wb_res;
                W_NP3:    npsc_reg[3]  <= wb_res;
                W_MEAN:   mean_reg     <= wb_res;
                W_DAMP:   damp_reg     <= wb_res;
                W_CAND:   cand_reg     <= wb_res;
                W_R26:    r26_reg      <= wb_res;
                W_ADAPT0: adapt_reg[0] <= wb_res;
                W_ADAPT1: adapt_reg[1] <= wb_res;
                default: ;
            endcase
        end
        if (cmd.spike1) begin
            before_reg <= before_c;
            margin_reg <= fx_add(before_c, fx_neg(threshold_reg));
            sub_reg    <= fx_neg(fx_add(FX_ONE, fx_neg(r26_reg)));
        end
        if (cmd.spike2) begin
            fired_reg <= fired_c;
            if (hard_reg) begin
                nv_reg <= fired_c ? r26_reg : before_reg;
            end else begin
                nv_reg <= fired_c ? fx_add(before_reg, sub_reg) : before_reg;
            end
            if (fired_c) begin
                nr_reg <= period_reg;
            end else begin
                nr_reg <= active ? 15'd0 : refr_reg - 15'd1;
            end
        end
    end

    // state write back, or zeros during the clearing pass
    always_comb begin
        row_wdata.volt     = nv_reg;
        row_wdata.refr     = nr_reg;
        row_wdata.adapt[0] = adapt_reg[0];
        row_wdata.adapt[1] = adapt_reg[1];
        for (int b = 0; b < BASIS_COUNT; b++) begin
            row_wdata.rise[b] = nrise_reg[b];
            row_wdata.psc[b]  = npsc_reg[b];
        end
        if (cmd.clearing) begin
            row_wdata = '0;
        end
    end

    assign row_we    = cmd.clearing || cmd.write;
    assign row_waddr = cmd.clearing ? clr_cnt_reg : NW'(n_reg);

    // result register
    logic               m_valid_reg;
    logic [7:0]         m_neuron_reg;
    logic               m_spiked_reg;
    logic signed [31:0] m_margin_reg;
    logic signed [31:0] m_voltage_reg;
    logic [14:0]        m_refr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.write) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.write) begin
            m_neuron_reg  <= n_reg;
            m_spiked_reg  <= fired_reg;
            m_margin_reg  <= margin_reg;
            m_voltage_reg <= nv_reg;
            m_refr_reg    <= nr_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_neuron_out      = m_neuron_reg;
    assign m_spiked          = m_spiked_reg;
    assign m_margin          = m_margin_reg;
    assign m_voltage_out     = m_voltage_reg;
    assign m_refractory_left = m_refr_reg;

    assign sts.clear_last = (clr_cnt_reg == NW'(NUM_NEURONS - 1));
    assign sts.in_range   = (32'(s_neuron) < 32'(NUM_NEURONS));
    assign sts.out_busy   = m_valid_reg && !m_ready;
endmodule

// ===== hw/rtl/glif_neuron_step_with_spike_core.sv =====
// ---------------------------------------------------------------------------
// glif neuron step with spike core
// one generalized leaky integrate-and-fire neuron update per step transfer
// ---------------------------------------------------------------------------
// A step item occupies the block while one shared 32x32 multiply-add unit
// runs 44 micro-ops, each a multiply step and then a round, saturate and add
// step, around a state fetch, the spike check and the write back; the block
// takes the next item in the cycle after the result is registered. A load item
// (mode 1) is written to memory and leaves the block ready. After reset a
// clearing pass zeroes the state of every neuron, during which no item is
// taken; configuration writes are taken at any time. Items whose neuron index is
// NUM_NEURONS or more are taken and dropped.
module glif_neuron_step_with_spike_core #(
    parameter int NUM_NEURONS = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [7:0]         s_neuron,
    input  logic [4:0]         s_slot,
    input  logic signed [31:0] s_coefficient,
    input  logic signed [31:0] s_current_0,
    input  logic signed [31:0] s_current_1,
    input  logic signed [31:0] s_current_2,
    input  logic signed [31:0] s_current_3,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_neuron_out,
    output logic               m_spiked,
    output logic signed [31:0] m_margin,
    output logic signed [31:0] m_voltage_out,
    output logic [14:0]        m_refractory_left
);
    import glif_pkg::*;

    glif_cmd_t cmd;
    glif_sts_t sts;

    assign cfg_ready = 1'b1;

    glif_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    glif_dp #(.NUM_NEURONS(NUM_NEURONS)) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .sts               (sts),
        .s_neuron          (s_neuron),
        .s_slot            (s_slot),
        .s_coefficient     (s_coefficient),
        .s_current_0       (s_current_0),
        .s_current_1       (s_current_1),
        .s_current_2       (s_current_2),
        .s_current_3       (s_current_3),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_neuron_out      (m_neuron_out),
        .m_spiked          (m_spiked),
        .m_margin          (m_margin),
        .m_voltage_out     (m_voltage_out),
        .m_refractory_left (m_refractory_left)
    );
endmodule

// ===== hw/rtl/glif_chk.sv =====
// ---------------------------------------------------------------------------
// glif port checker
// temporal checks on the top-level ports, bound to the core
// ---------------------------------------------------------------------------
`include "glif_neuron_step_with_spike_core_macros.svh"

module glif_chk #(
    parameter int NUM_NEURONS = 256
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               s_mode,
    input logic [7:0]         s_neuron,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_spiked,
    input logic signed [31:0] m_margin,
    input logic signed [31:0] m_voltage_out
);
    // a stalled result holds
    `GLIF_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_voltage_out), "stalled result changed")

    // a step transfer makes the block busy
    `GLIF_ASSERT_NXT(a_busy_after_step, aclk, aresetn, s_valid && s_ready && !s_mode && (32'(s_neuron) < 32'(NUM_NEURONS)), !s_ready, "block took a new item during a step")

    // results appear only from the busy state
    `GLIF_ASSERT_IMP(a_result_from_busy, aclk, aresetn, $rose(m_valid), $past(!s_ready), "result while idle")

    // a spike implies a positive margin
    `GLIF_ASSERT_IMP(a_spike_margin, aclk, aresetn, m_valid && m_spiked, !m_margin[31] && (m_margin != 32'sd0), "spike without positive margin")
endmodule

bind glif_neuron_step_with_spike_core glif_chk #(.NUM_NEURONS(NUM_NEURONS)) u_chk (.*);

// ===== dv/tb_glif_neuron_step_with_spike_core.sv =====
// ---------------------------------------------------------------------------
// glif neuron step with spike core testbench
// loads coefficients and steps neurons through the stream ports, predicts
// results with a fixed-point bench neuron model or takes them from typed rows,
// compares results in order, over several register settings and idle mixes
// ---------------------------------------------------------------------------
module tb_glif_neuron_step_with_spike_core;
    timeunit 1ns;
    timeprecision 1ps;

    import glif_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int POOL_SIZE = 18;

    typedef struct {
        logic [7:0]         neuron;
        logic               spiked;
        logic signed [31:0] margin;
        logic signed [31:0] voltage;
        logic [14:0]        refr;
    } spike_result_t;

    typedef struct {
        bit                 mode;
        bit [7:0]           neuron;
        bit [4:0]           slot;
        logic signed [31:0] coef;
        logic [3:0][31:0]   cur;
        bit                 typed;
        spike_result_t      want;
    } stim_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_mode;
    logic [7:0]         s_neuron;
    logic [4:0]         s_slot;
    logic signed [31:0] s_coefficient;
    logic signed [31:0] s_current_0;
    logic signed [31:0] s_current_1;
    logic signed [31:0] s_current_2;
    logic signed [31:0] s_current_3;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               m_valid;
    logic               m_ready;
    logic [7:0]         m_neuron_out;
    logic               m_spiked;
    logic signed [31:0] m_margin;
    logic signed [31:0] m_voltage_out;
    logic [14:0]        m_refractory_left;

    glif_neuron_step_with_spike_core u_dut (.*);

    // neuron model state
    logic signed [31:0] step_reg;
    logic signed [31:0] thr_reg;
    logic               hard_mode;
    logic signed [31:0] volt_mem [256];
    logic [14:0]        refr_mem [256];
    logic signed [31:0] adapt_mem [512];
    logic signed [31:0] rise_mem [1024];
    logic signed [31:0] psc_mem [1024];
    logic signed [31:0] coef_mem [7168];
    logic [14:0]        period_mem [256];

    spike_result_t pending_results[$];
    int  mismatches = 0;
    int  send_idle  = 0;
    int  recv_stall = 0;
    stim_row_t dir_rows[$];

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("glif_neuron_step_with_spike_core regression: fail");
        $finish;
    end

    function automatic logic signed [31:0] q_sat(input longint x);
        if (x > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end
        if (x < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] q_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return q_sat(longint'(a) + longint'(b));
    endfunction

    function automatic logic signed [31:0] q_neg(input logic signed [31:0] a);
        return q_sat(-longint'(a));
    endfunction

    // round to nearest, ties up: floor((a*b + half) / one)
    function automatic logic signed [31:0] q_mul(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b) + 64'sd8388608;
        return q_sat(p >>> 24);
    endfunction

    function automatic spike_result_t step_neuron(input logic [7:0] n,
                                                  input logic [3:0][31:0] cur);
        spike_result_t      res;
        logic signed [31:0] c [28];
        logic signed [31:0] contrib [4];
        logic signed [31:0] v, mean, rs, pc, integ, keep, damp, cand, pre, marg, nv, a;
        logic [14:0]        r, nr;
        bit                 active, fired;
        int                 k;
        for (int i = 0; i < 28; i++) c[i] = coef_mem[n * 28 + i];
        v = volt_mem[n];
        r = refr_mem[n];
        active = (r == 0);
        mean = q_add(q_mul(adapt_mem[2 * n], c[14]), q_mul(adapt_mem[2 * n + 1], c[15]));
        for (int b = 0; b < 4; b++) begin
            k = n * 4 + b;
            rs = rise_mem[k];
            pc = psc_mem[k];
            contrib[b] = q_add(q_mul(pc, c[18 + b]), q_mul(rs, c[22 + b]));
            rise_mem[k] = q_add(q_mul(rs, c[b]), q_mul(cur[b], c[4 + b]));
            psc_mem[k] = q_add(q_mul(pc, c[b]), q_mul(q_mul(step_reg, c[b]), rs));
        end
        integ = q_add(q_add(contrib[0], contrib[1]), q_add(contrib[2], contrib[3]));
        keep = q_add(FX_ONE, q_neg(c[27]));
        damp = q_add(q_mul(v, keep), q_mul(v, c[27]));
        cand = q_add(q_mul(c[12], damp), q_add(q_mul(c[13], mean), integ));
        pre = (hard_mode && !active) ? c[26] : cand;
        marg = q_add(pre, q_neg(thr_reg));
        fired = active && (marg > 0);
        if (hard_mode) begin
            nv = fired ? c[26] : pre;
        end else begin
            nv = fired ? q_add(pre, q_neg(q_add(FX_ONE, q_neg(c[26])))) : pre;
        end
        nr = fired ? period_mem[n] : ((r > 0) ? r - 15'd1 : 15'd0);
        for (int b = 0; b < 2; b++) begin
            a = adapt_mem[2 * n + b];
            if (active) a = q_mul(a, c[8 + b]);
            if (fired) a = q_add(c[10 + b], q_mul(a, c[16 + b]));
            adapt_mem[2 * n + b] = a;
        end
        volt_mem[n] = nv;
        refr_mem[n] = nr;
        res.neuron  = n;
        res.spiked  = fired;
        res.margin  = marg;
        res.voltage = nv;
        res.refr    = nr;
        return res;
    endfunction

    function automatic logic signed [31:0] rand_q();
        if ($urandom_range(0, 7) == 0) begin
            return $urandom;
        end
        return int'($urandom_range(0, 32'h0300_0000)) - 32'sh0180_0000;
    endfunction

    function automatic logic signed [31:0] rand_cur();
        if ($urandom_range(0, 5) == 0) begin
            return $urandom;
        end
        return int'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
    endfunction

    function automatic logic signed [31:0] rand_period();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom;
        end
        return $urandom_range(0, 4);
    endfunction

    // profiles: 0 all zero, 1 unit gains that fire easily, 2 random
    function automatic logic signed [31:0] profile_coef(input int kind, input int slot);
        if (kind == 0) begin
            return 0;
        end
        if (kind == 2) begin
            return (slot == PERIOD_SLOT) ? rand_period() : rand_q();
        end
        case (slot)
            8, 9, 27:   return 32'sd8388608;
            10, 11, 26: return 32'sd4194304;
            28:         return 32'sd3;
            default:    return FX_ONE;
        endcase
    endfunction

    function automatic bit [7:0] pick_pool();
        int r;
        r = $urandom_range(0, POOL_SIZE - 1);
        return (r < 16) ? r[7:0] : ((r == 16) ? 8'd128 : 8'd255);
    endfunction

    task automatic push_item(input stim_row_t row);
        int idle;
        spike_result_t res;
        idle = 0;
        while ($urandom_range(0, 99) < send_idle) idle++;
        if (idle > 0) begin
            s_valid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= row.mode;
        s_neuron      <= row.neuron;
        s_slot        <= row.slot;
        s_coefficient <= row.coef;
        s_current_0   <= row.cur[0];
        s_current_1   <= row.cur[1];
        s_current_2   <= row.cur[2];
        s_current_3   <= row.cur[3];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (row.mode) begin
            if (row.slot < PERIOD_SLOT) begin
                coef_mem[row.neuron * 28 + row.slot] = row.coef;
            end else if (row.slot == PERIOD_SLOT) begin
                period_mem[row.neuron] = row.coef[14:0];
            end
        end else begin
            res = step_neuron(row.neuron, row.cur);
            pending_results.push_back(row.typed ? row.want : res);
        end
    endtask

    task automatic load_coef(input bit [7:0] n, input bit [4:0] slot,
                             input logic signed [31:0] value);
        stim_row_t row;
        row = '{mode: 1'b1, neuron: n, slot: slot, coef: value, cur: '0,
                typed: 1'b0, want: '{default: '0}};
        push_item(row);
    endtask

    task automatic step_item(input bit [7:0] n, input logic [3:0][31:0] cur);
        stim_row_t row;
        row = '{mode: 1'b0, neuron: n, slot: 5'($urandom), coef: $urandom, cur: cur,
                typed: 1'b0, want: '{default: '0}};
        push_item(row);
    endtask

    // leaves cfg_valid high so that back-to-back writes need one assignment
    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (index)
            REG_TIME_STEP:  step_reg  = value;
            REG_THRESHOLD:  thr_reg   = value;
            REG_HARD_RESET: hard_mode = value[0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    function automatic void add_dir(input bit mode, input bit [7:0] n, input bit [4:0] slot,
                                    input logic signed [31:0] coef,
                                    input logic [3:0][31:0] cur, input bit typed);
        stim_row_t row;
        row.mode   = mode;
        row.neuron = n;
        row.slot   = slot;
        row.coef   = coef;
        row.cur    = cur;
        row.typed  = typed;
        // typed rows all hit the zero-coefficient neuron at reset settings
        row.want   = '{neuron: n, spiked: 1'b0, margin: -32'sd16777216,
                       voltage: 32'sd0, refr: 15'd0};
        dir_rows.push_back(row);
    endfunction

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall);
    end

    always @(posedge aclk) begin
        spike_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result transfer: neuron %0d", m_neuron_out);
                end
            end else begin
                want = pending_results.pop_front();
                if (m_neuron_out !== want.neuron || m_spiked !== want.spiked ||
                    m_margin !== want.margin || m_voltage_out !== want.voltage ||
                    m_refractory_left !== want.refr) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected n=%0d s=%0d m=%h v=%h r=%0d, got n=%0d s=%0d m=%h v=%h r=%0d",
                                 want.neuron, want.spiked, want.margin, want.voltage,
                                 want.refr, m_neuron_out, m_spiked, m_margin,
                                 m_voltage_out, m_refractory_left);
                    end
                end
            end
        end
    end

    initial begin
        logic [3:0][31:0] cur;
        stim_row_t row;
        int kind;
        int idle_mix [4][2] = '{'{0, 0}, '{75, 0}, '{0, 75}, '{32, 32}};
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_mode = 1'b0;
        s_neuron = '0;
        s_slot = '0;
        s_coefficient = '0;
        s_current_0 = '0;
        s_current_1 = '0;
        s_current_2 = '0;
        s_current_3 = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_TIME_STEP;
        cfg_data = '0;
        m_ready = 1'b0;
        step_reg = 0;
        thr_reg = FX_ONE;
        hard_mode = 1'b0;
        for (int i = 0; i < 256; i++) begin
            volt_mem[i] = 0;
            refr_mem[i] = 0;
            period_mem[i] = 0;
        end
        for (int i = 0; i < 512; i++) adapt_mem[i] = 0;
        for (int i = 0; i < 1024; i++) begin
            rise_mem[i] = 0;
            psc_mem[i] = 0;
        end
        for (int i = 0; i < 7168; i++) coef_mem[i] = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every neuron that is ever stepped gets all of its coefficients first
        for (int p = 0; p < POOL_SIZE; p++) begin
            kind = (p == 0) ? 0 : ((p == 1) ? 1 : 2);
            for (int s = 0; s <= PERIOD_SLOT; s++) begin
                load_coef(8'((p < 16) ? p : ((p == 16) ? 128 : 255)), 5'(s),
                          profile_coef(kind, s));
            end
        end

        add_dir(1'b0, 8'd0, 5'd0, 0, '0, 1'b1);
        add_dir(1'b0, 8'd0, 5'd31, 32'sh7FFFFFFF, {4{32'h7FFFFFFF}}, 1'b1);
        add_dir(1'b0, 8'd0, 5'd0, 32'sh80000000, {4{32'h80000000}}, 1'b1);
        add_dir(1'b1, 8'd0, 5'd29, -32'sd1, '0, 1'b0);
        add_dir(1'b1, 8'd0, 5'd31, 32'sh7FFFFFFF, '0, 1'b0);
        add_dir(1'b0, 8'd0, 5'd0, 0, {4{32'h0100_0000}}, 1'b1);
        for (int i = 0; i < 5; i++) add_dir(1'b0, 8'd1, 5'd0, 0, {4{32'h0200_0000}}, 1'b0);
        add_dir(1'b1, 8'd1, PERIOD_SLOT, 32'shFFFFFFFF, '0, 1'b0);
        for (int i = 0; i < 3; i++) add_dir(1'b0, 8'd1, 5'd0, 0, {4{32'h7FFFFFFF}}, 1'b0);
        add_dir(1'b0, 8'd255, 5'd0, 0, {4{32'h80000000}}, 1'b0);
        add_dir(1'b0, 8'd255, 5'd0, 0, {4{32'h7FFFFFFF}}, 1'b0);
        // negating the most negative value saturates
        add_dir(1'b1, 8'd2, 5'd27, 32'sh80000000, '0, 1'b0);
        add_dir(1'b1, 8'd2, 5'd12, 32'sh7FFFFFFF, '0, 1'b0);
        add_dir(1'b0, 8'd2, 5'd0, 0, {4{32'h7FFFFFFF}}, 1'b0);
        add_dir(1'b0, 8'd2, 5'd0, 0, {4{32'h80000000}}, 1'b0);
        foreach (dir_rows[i]) push_item(dir_rows[i]);

        for (int ph = 0; ph < 4; ph++) begin
            s_valid <= 1'b0;
            drain();
            send_idle  = idle_mix[ph][0];
            recv_stall = idle_mix[ph][1];
            case (ph)
                0: begin
                    write_reg(REG_TIME_STEP, 32'h7FFFFFFF);
                    write_reg(REG_THRESHOLD, 32'h80000000);
                    write_reg(REG_HARD_RESET, 32'd1);
                end
                1: begin
                    write_reg(REG_TIME_STEP, 32'h80000000);
                    write_reg(REG_THRESHOLD, 32'h7FFFFFFF);
                    write_reg(REG_HARD_RESET, 32'hFFFFFFFE);
                    write_reg(REG_SPARE, $urandom);
                end
                2: begin
                    write_reg(REG_TIME_STEP, 32'h0040_0000);
                    write_reg(REG_THRESHOLD, 32'h0080_0000);
                    write_reg(REG_HARD_RESET, 32'd0);
                end
                default: begin
                    write_reg(REG_TIME_STEP, rand_q());
                    write_reg(REG_THRESHOLD, $urandom_range(0, 32'h0200_0000));
                    write_reg(REG_HARD_RESET, 32'd1);
                end
            endcase
            cfg_valid <= 1'b0;
            for (int i = 0; i < 250; i++) begin
                if ($urandom_range(0, 99) < 80) begin
                    for (int b = 0; b < 4; b++) cur[b] = rand_cur();
                    step_item(pick_pool(), cur);
                end else if ($urandom_range(0, 3) == 0) begin
                    // loads to random neurons, stepped or not, any slot
                    load_coef(8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)), $urandom);
                end else begin
                    row.slot = 5'($urandom_range(0, 31));
                    load_coef(pick_pool(), row.slot,
                              (row.slot == PERIOD_SLOT) ? rand_period() : rand_q());
                end
            end
        end
        s_valid <= 1'b0;
        drain();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("glif_neuron_step_with_spike_core regression: pass");
        end else begin
            $display("glif_neuron_step_with_spike_core regression: fail");
        end
        $finish;
    end

endmodule
